// File: hdl/shsvg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package shsvg_pkg;

    localparam int AXES = 3;
    localparam int AXIS_W = 2;
    localparam int TICK_RATE = 20000;
    localparam int RATE_CEILING = 4000;
    localparam int RATE_W = 12;
    localparam int SPEED_W = 13;
    localparam int PHASE_W = 17;

    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_CMD  = 2'd1;
    localparam logic [1:0] ACT_STOP = 2'd2;

    localparam logic CFG_MAX_RATE = 1'b0;
    localparam logic CFG_RELEASE  = 1'b1;

    typedef struct packed {
        logic signed [SPEED_W-1:0] req_speed;
        logic signed [SPEED_W-1:0] app_speed;
        logic [31:0]               position;
        logic [PHASE_W-1:0]        phase;
        logic [2:0]                pidx;
        logic                      en;
        logic                      qstop;
        logic                      run;
        logic                      coils_on;
        logic                      clamp;
    } t_axis_state;

    localparam t_axis_state AXIS_RESET = '{
        req_speed: '0, app_speed: '0, position: '0, phase: '0, pidx: '0,
        en: 1'b0, qstop: 1'b1, run: 1'b0, coils_on: 1'b0, clamp: 1'b0
    };

    typedef struct packed {
        logic [1:0]  action;
        logic        enable;
        logic        quick_stop;
        logic        reset_position;
        logic [31:0] velocity;
        logic        disable_outputs;
    } t_request;

    function automatic logic [3:0] half_pattern(input logic [2:0] idx);
        logic [3:0] p;
        case (idx)
            3'd0: p = 4'b0001;
            3'd1: p = 4'b0011;
            3'd2: p = 4'b0010;
            3'd3: p = 4'b0110;
            3'd4: p = 4'b0100;
            3'd5: p = 4'b1100;
            3'd6: p = 4'b1000;
            3'd7: p = 4'b1001;
            default: p = 4'b0000;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// File: hdl/stepper_half_step_velocity_generator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake            Payload
// request   i_valid / o_stall    i_action, i_axis, i_enable, i_quick_stop,
//                                i_reset_position, i_velocity, i_disable_outputs
// result    o_valid / i_stall    o_axis_id, o_coils, o_position, o_applied_velocity,
//                                o_running, o_enabled, o_stopped_quick,
//                                o_velocity_clamped, o_energized, o_last
// config    i_cfg_we             i_cfg_idx, i_cfg_data
//
// Axis state sits in one synchronous memory, one entry per axis.
// Each reported axis passes through a memory read, an update and write back, and a
// result hand-off; a tick or stop all reports every axis, a command only its own axis.
// A dropped request (action 3, or a command to axis 3) is accepted and gives no result.
// Reset clears per-entry valid bits; an entry not yet written reads as the reset state.
// A stalled result holds the sequencer; no new request is taken until the last one leaves.

module stepper_half_step_velocity_generator (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [1:0]          i_action,
    input  wire logic [1:0]          i_axis,
    input  wire logic                i_enable,
    input  wire logic                i_quick_stop,
    input  wire logic                i_reset_position,
    input  wire logic signed [31:0]  i_velocity,
    input  wire logic                i_disable_outputs,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [1:0]               o_axis_id,
    output logic [3:0]               o_coils,
    output logic signed [31:0]       o_position,
    output logic signed [12:0]       o_applied_velocity,
    output logic                     o_running,
    output logic                     o_enabled,
    output logic                     o_stopped_quick,
    output logic                     o_velocity_clamped,
    output logic                     o_energized,
    output logic                     o_last,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_idx,
    input  wire logic [11:0]         i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EXEC = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state                            r_state;
    shsvg_pkg::t_request               r_req;
    logic [shsvg_pkg::AXIS_W-1:0]      r_ax;
    logic                              r_single;
    logic [shsvg_pkg::RATE_W-1:0]      r_max_rate;
    logic                              r_release;
    shsvg_pkg::t_axis_state            r_mem [0:shsvg_pkg::AXES-1];
    logic [shsvg_pkg::AXES-1:0]        r_vld;
    shsvg_pkg::t_axis_state            r_rd;
    logic                              r_rd_vld;
    shsvg_pkg::t_axis_state            w_cur;
    shsvg_pkg::t_axis_state            w_nxt;
    logic                              w_accept;
    logic                              w_drop;
    logic                              w_last;

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && (r_state == S_IDLE);
    assign w_drop   = (i_action != shsvg_pkg::ACT_TICK) && (i_action != shsvg_pkg::ACT_STOP) &&
                      !((i_action == shsvg_pkg::ACT_CMD) &&
                        (i_axis < shsvg_pkg::AXIS_W'(shsvg_pkg::AXES)));
    assign w_last   = r_single || (r_ax == shsvg_pkg::AXIS_W'(shsvg_pkg::AXES - 1));
    assign w_cur    = r_rd_vld ? r_rd : shsvg_pkg::AXIS_RESET;

    shsvg_axis_alu u_alu (
        .i_req      (r_req),
        .i_cur      (w_cur),
        .i_max_rate (r_max_rate),
        .i_release  (r_release),
        .o_nxt      (w_nxt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_rate <= shsvg_pkg::RATE_W'(shsvg_pkg::RATE_CEILING);
            r_release  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                shsvg_pkg::CFG_MAX_RATE: r_max_rate <= i_cfg_data;
                shsvg_pkg::CFG_RELEASE:  r_release  <= i_cfg_data[0];
                default:                 r_release  <= r_release;
            endcase
        end
    end

    // state memory: registered read, write back in the update cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_rd <= r_mem[r_ax];
        end
        if (r_state == S_EXEC) begin
            r_mem[r_ax] <= w_nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (r_state == S_READ) begin
                r_rd_vld <= r_vld[r_ax];
            end
            if (r_state == S_EXEC) begin
                r_vld[r_ax] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req.action          <= i_action;
            r_req.enable          <= i_enable;
            r_req.quick_stop      <= i_quick_stop;
            r_req.reset_position  <= i_reset_position;
            r_req.velocity        <= i_velocity;
            r_req.disable_outputs <= i_disable_outputs;
            r_single              <= (i_action == shsvg_pkg::ACT_CMD);
        end
        if (r_state == S_EXEC) begin
            o_axis_id          <= r_ax;
            o_coils            <= w_nxt.coils_on ? shsvg_pkg::half_pattern(w_nxt.pidx) : 4'b0000;
            o_position         <= w_nxt.position;
            o_applied_velocity <= w_nxt.app_speed;
            o_running          <= w_nxt.run;
            o_enabled          <= w_nxt.en;
            o_stopped_quick    <= w_nxt.qstop;
            o_velocity_clamped <= w_nxt.clamp;
            o_energized        <= w_nxt.coils_on;
            o_last             <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ax    <= '0;
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept && !w_drop) begin
                        r_ax    <= (i_action == shsvg_pkg::ACT_CMD) ? i_axis : '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    o_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold until the result is taken, then advance to the next axis or, after the last, return to idle
                    if (!i_stall) begin
                        o_valid <= 1'b0;
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_ax    <= r_ax + shsvg_pkg::AXIS_W'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    o_valid <= 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hdl/shsvg_axis_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module shsvg_axis_alu (
    input  wire shsvg_pkg::t_request                i_req,
    input  wire shsvg_pkg::t_axis_state             i_cur,
    input  wire logic [shsvg_pkg::RATE_W-1:0]       i_max_rate,
    input  wire logic                               i_release,
    output shsvg_pkg::t_axis_state                  o_nxt
);

    logic [shsvg_pkg::RATE_W-1:0]  w_lim;
    logic signed [31:0]            w_plim;
    logic signed [31:0]            w_nlim;
    logic signed [31:0]            w_vel;
    logic [shsvg_pkg::SPEED_W-1:0] w_neg;
    logic [shsvg_pkg::RATE_W-1:0]  w_mag;
    logic [shsvg_pkg::PHASE_W:0]   w_sum;
    logic [shsvg_pkg::PHASE_W-1:0] w_acc;

    always_comb begin
        if (i_max_rate == '0) begin
            w_lim = shsvg_pkg::RATE_W'(1);
        end else if (i_max_rate > shsvg_pkg::RATE_W'(shsvg_pkg::RATE_CEILING)) begin
            w_lim = shsvg_pkg::RATE_W'(shsvg_pkg::RATE_CEILING);
        end else begin
            w_lim = i_max_rate;
        end
    end

    assign w_plim = signed'({{(32-shsvg_pkg::RATE_W){1'b0}}, w_lim});
    assign w_nlim = -w_plim;
    assign w_vel  = signed'(i_req.velocity);
    assign w_neg  = -i_cur.req_speed;
    assign w_mag  = i_cur.req_speed[shsvg_pkg::SPEED_W-1] ?
                    w_neg[shsvg_pkg::RATE_W-1:0] : i_cur.req_speed[shsvg_pkg::RATE_W-1:0];
    assign w_sum  = {1'b0, i_cur.phase} + {{(shsvg_pkg::PHASE_W+1-shsvg_pkg::RATE_W){1'b0}}, w_mag};
    assign w_acc  = w_sum[shsvg_pkg::PHASE_W-1:0];

    always_comb begin
        o_nxt = i_cur;
        case (i_req.action)
            shsvg_pkg::ACT_TICK: begin
                if (!i_cur.en) begin
                    o_nxt.app_speed = '0;
                    o_nxt.run       = 1'b0;
                    o_nxt.phase     = '0;
                    if (i_release) begin
                        o_nxt.coils_on = 1'b0;
                    end
                end else begin
                    o_nxt.coils_on = 1'b1;
                    if (i_cur.qstop || i_cur.req_speed == '0) begin
                        o_nxt.app_speed = '0;
                        o_nxt.run       = 1'b0;
                        o_nxt.phase     = '0;
                    end else begin
                        o_nxt.app_speed = i_cur.req_speed;
                        o_nxt.run       = 1'b1;
                        o_nxt.phase     = w_acc;
                        // on phase overflow, move one half step in the direction of the speed's sign
                        if (w_acc >= shsvg_pkg::PHASE_W'(shsvg_pkg::TICK_RATE)) begin
                            o_nxt.phase = w_acc - shsvg_pkg::PHASE_W'(shsvg_pkg::TICK_RATE);
                            if (!i_cur.req_speed[shsvg_pkg::SPEED_W-1]) begin
                                o_nxt.pidx     = i_cur.pidx + 3'd1;
                                o_nxt.position = i_cur.position + 32'd1;
                            end else begin
                                o_nxt.pidx     = i_cur.pidx - 3'd1;
                                o_nxt.position = i_cur.position - 32'd1;
                            end
                        end
                    end
                end
            end
            shsvg_pkg::ACT_CMD: begin
                if (i_req.reset_position) begin
                    o_nxt.position = '0;
                    o_nxt.phase    = '0;
                end
                if (w_vel > w_plim) begin
                    o_nxt.req_speed = w_plim[shsvg_pkg::SPEED_W-1:0];
                    o_nxt.clamp     = 1'b1;
                end else if (w_vel < w_nlim) begin
                    o_nxt.req_speed = w_nlim[shsvg_pkg::SPEED_W-1:0];
                    o_nxt.clamp     = 1'b1;
                end else begin
                    o_nxt.req_speed = w_vel[shsvg_pkg::SPEED_W-1:0];
                    o_nxt.clamp     = 1'b0;
                end
                o_nxt.en    = i_req.enable;
                o_nxt.qstop = i_req.quick_stop;
                if (!i_req.enable || i_req.quick_stop) begin
                    o_nxt.app_speed = '0;
                    o_nxt.run       = 1'b0;
                    o_nxt.phase     = '0;
                end
            end
            shsvg_pkg::ACT_STOP: begin
                o_nxt.req_speed = '0;
                o_nxt.qstop     = 1'b1;
                o_nxt.app_speed = '0;
                o_nxt.run       = 1'b0;
                o_nxt.phase     = '0;
                if (i_req.disable_outputs) begin
                    o_nxt.en = 1'b0;
                end
            end
            default: begin
                o_nxt = i_cur;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/shsvg_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module shsvg_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire logic [1:0]         o_axis_id,
    input wire logic [3:0]         o_coils,
    input wire logic signed [31:0] o_position,
    input wire logic signed [12:0] o_applied_velocity,
    input wire logic               o_running,
    input wire logic               o_enabled,
    input wire logic               o_energized,
    input wire logic               o_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_position) && $stable(o_axis_id))
        else $error("stalled result changed");

    a_last_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_axis_id == 2'd2) |-> o_last)
        else $error("final axis result not marked last");

    a_coils: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_energized && o_coils == 4'd0) ||
                    (o_energized && ($countones(o_coils) == 1 || $countones(o_coils) == 2)))
        else $error("coil pattern does not match energized flag");

    a_disabled_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_enabled |-> !o_running && o_applied_velocity == 13'sd0)
        else $error("disabled axis reports motion");

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_axis_id != 2'd3)
        else $error("result for nonexistent axis");

endmodule

bind stepper_half_step_velocity_generator shsvg_checker u_shsvg_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_axis_id          (o_axis_id),
    .o_coils            (o_coils),
    .o_position         (o_position),
    .o_applied_velocity (o_applied_velocity),
    .o_running          (o_running),
    .o_enabled          (o_enabled),
    .o_energized        (o_energized),
    .o_last             (o_last)
);

`default_nettype wire
